### rtl/vps_pkg.sv
// vps_pkg: shared constants for the viewshed profile sweep.
// Field widths, sizing limits, command and record codes.
// No dependencies.
package vps_pkg;

  // Sizing limits
  localparam int unsigned DEM_POINTS  = 1048576;
  localparam int unsigned MAX_SECTORS = 2048;

  // Field widths
  localparam int DIST_W  = 20;
  localparam int ELEV_W  = 24;
  localparam int IDX_W   = 20;
  localparam int OBS_W   = 20;
  localparam int LEVEL_W = 25;   // elevation plus observer height
  localparam int RISE_W  = 26;   // signed height difference
  localparam int RUNS_W  = 21;   // run as a signed multiplier operand
  localparam int PROD_W  = 47;   // RISE_W + RUNS_W
  localparam int SQ_W    = 41;   // unsigned square of a run, with headroom
  localparam int SURF_W  = 40;
  localparam int CNT_W   = 12;

  // Derived limits
  localparam logic [IDX_W-1:0]  IDX_MAX  = IDX_W'(DEM_POINTS - 1);
  localparam logic [CNT_W-1:0]  RING_MAX = CNT_W'(MAX_SECTORS);
  localparam logic [SURF_W-1:0] SURF_MAX = {SURF_W{1'b1}};

  // Slope used before any maximum exists
  localparam logic signed [RISE_W-1:0] NOMAX_SLOPE = -26'sd2000;

  // Command codes
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_POINT = 1'b1;

  // Result record kinds
  localparam logic KIND_SECTOR = 1'b0;
  localparam logic KIND_TOTAL  = 1'b1;

endpackage

### rtl/viewshed_profile_sweep.sv
// viewshed_profile_sweep: line-of-sight sweep over one profile, emitting ring
// sector records and a profile total. Depends on vps_pkg.
// Steps: a start item is taken in ST_IDLE; a profile point passes accept, two slope
// products and decide. Closing a sector adds two squares and the accumulate, then
// the sector record and, on a last item, the total record; records wait while the
// output stalls. The single 26x21 multiplier forms the products and squares in turn.
// Reset: synchronous, active low.
module viewshed_profile_sweep (
  input  logic                        clk,
  input  logic                        rst_n,
  // configuration write
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [vps_pkg::OBS_W-1:0]   cfg_observer_height,
  // input items
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_command,
  input  logic                        in_direction,
  input  logic [vps_pkg::DIST_W-1:0]  in_distance,
  input  logic [vps_pkg::ELEV_W-1:0]  in_elevation,
  input  logic [vps_pkg::IDX_W-1:0]   in_point_index,
  input  logic                        in_last,
  // result items
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_kind,
  output logic [vps_pkg::IDX_W-1:0]   out_open_index,
  output logic [vps_pkg::IDX_W-1:0]   out_close_index,
  output logic [vps_pkg::SURF_W-1:0]  out_surface,
  output logic [vps_pkg::CNT_W-1:0]   out_sector_count,
  output logic                        out_last_result
);

  // Sequencer states
  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_MUL1   = 4'd1;
  localparam logic [3:0] ST_MUL2   = 4'd2;
  localparam logic [3:0] ST_DECIDE = 4'd3;
  localparam logic [3:0] ST_SQ1    = 4'd4;
  localparam logic [3:0] ST_SQ2    = 4'd5;
  localparam logic [3:0] ST_ACCUM  = 4'd6;
  localparam logic [3:0] ST_SECT   = 4'd7;
  localparam logic [3:0] ST_TOTAL  = 4'd8;

  // DEM size as a 32-bit compare operand
  localparam logic [31:0] DEM_POINTS_32 = 32'(vps_pkg::DEM_POINTS);

  // Control and profile state
  logic [3:0]                         state_r, state_nxt;
  logic [vps_pkg::OBS_W-1:0]          obs_height_r, obs_height_nxt;
  logic [vps_pkg::DIST_W-1:0]         eye_distance_r, eye_distance_nxt;
  logic [vps_pkg::LEVEL_W-1:0]        eye_level_r, eye_level_nxt;
  logic                               sweep_backward_r, sweep_backward_nxt;
  logic                               visible_r, visible_nxt;
  logic                               have_max_r, have_max_nxt;
  logic signed [vps_pkg::RISE_W-1:0]  max_rise_r, max_rise_nxt;
  logic [vps_pkg::DIST_W-1:0]         max_run_r, max_run_nxt;
  logic [vps_pkg::DIST_W-1:0]         open_run_r, open_run_nxt;
  logic [vps_pkg::IDX_W-1:0]          open_point_r, open_point_nxt;
  logic [vps_pkg::IDX_W-1:0]          latest_point_r, latest_point_nxt;
  logic [vps_pkg::DIST_W-1:0]         latest_run_r, latest_run_nxt;
  logic [vps_pkg::SURF_W-1:0]         surface_sum_r, surface_sum_nxt;
  logic [vps_pkg::CNT_W-1:0]          ring_count_r, ring_count_nxt;
  logic                               total_pend_r, total_pend_nxt;

  // Working registers
  logic signed [vps_pkg::RISE_W-1:0]  rise_r, rise_nxt;
  logic                               last_r, last_nxt;
  logic signed [vps_pkg::PROD_W-1:0]  p1_r, p1_nxt;
  logic signed [vps_pkg::PROD_W-1:0]  p2_r, p2_nxt;

  // Output register
  logic                               out_valid_r, out_valid_nxt;
  logic                               out_kind_r, out_kind_nxt;
  logic [vps_pkg::IDX_W-1:0]          out_open_r, out_open_nxt;
  logic [vps_pkg::IDX_W-1:0]          out_close_r, out_close_nxt;
  logic [vps_pkg::SURF_W-1:0]         out_surface_r, out_surface_nxt;
  logic [vps_pkg::CNT_W-1:0]          out_count_r, out_count_nxt;
  logic                               out_last_r, out_last_nxt;

  // Shared multiplier
  logic signed [vps_pkg::RISE_W-1:0]  mul_a;
  logic signed [vps_pkg::RUNS_W-1:0]  mul_b;
  logic signed [vps_pkg::PROD_W-1:0]  mul_p;

  // Input side helpers
  logic                               in_take;
  logic                               out_free;
  logic [vps_pkg::IDX_W-1:0]          idx_clamped;
  logic signed [vps_pkg::RUNS_W-1:0]  run_diff;
  logic [vps_pkg::DIST_W-1:0]         run_in;
  logic signed [vps_pkg::RISE_W-1:0]  rise_in;

  // Decide and accumulate helpers
  logic                               above;
  logic                               close_now;
  logic signed [vps_pkg::SURF_W+1:0]  surf_sum;

  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = (state_r == ST_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  // Index clamp to the DEM size
  assign idx_clamped = ({12'd0, in_point_index} >= DEM_POINTS_32) ? vps_pkg::IDX_MAX
                                                                  : in_point_index;

  // Run and rise of an incoming point; a point behind the eye gets run zero
  assign run_diff = sweep_backward_r
                  ? (signed'({1'b0, eye_distance_r}) - signed'({1'b0, in_distance}))
                  : (signed'({1'b0, in_distance}) - signed'({1'b0, eye_distance_r}));
  assign run_in   = run_diff[vps_pkg::RUNS_W-1] ? '0 : run_diff[vps_pkg::DIST_W-1:0];
  assign rise_in  = signed'({2'b00, in_elevation}) - signed'({1'b0, eye_level_r});

  // Operand selection for the shared multiplier
  always_comb begin
    mul_a = rise_r;
    mul_b = 21'sd1;
    case (state_r)
      ST_MUL1: begin
        mul_a = rise_r;
        mul_b = have_max_r ? signed'({1'b0, max_run_r}) : 21'sd1;
      end
      ST_MUL2: begin
        mul_a = have_max_r ? max_rise_r : vps_pkg::NOMAX_SLOPE;
        mul_b = signed'({1'b0, latest_run_r});
      end
      ST_SQ1: begin
        mul_a = signed'({6'd0, latest_run_r});
        mul_b = signed'({1'b0, latest_run_r});
      end
      ST_SQ2: begin
        mul_a = signed'({6'd0, open_run_r});
        mul_b = signed'({1'b0, open_run_r});
      end
      default: begin
        mul_a = rise_r;
        mul_b = 21'sd1;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Slope test: cross products in p1 and p2; zero run is never above
  assign above     = (latest_run_r != '0) && (p1_r > p2_r);
  assign close_now = (!above && visible_r) || (last_r && above);

  // Surface update with clamping at both ends
  assign surf_sum = signed'({2'b00, surface_sum_r})
                  + signed'({1'b0, p1_r[vps_pkg::SQ_W-1:0]})
                  - signed'({1'b0, p2_r[vps_pkg::SQ_W-1:0]});

  // Sequencer and next-state logic
  always_comb begin
    state_nxt          = state_r;
    obs_height_nxt     = obs_height_r;
    eye_distance_nxt   = eye_distance_r;
    eye_level_nxt      = eye_level_r;
    sweep_backward_nxt = sweep_backward_r;
    visible_nxt        = visible_r;
    have_max_nxt       = have_max_r;
    max_rise_nxt       = max_rise_r;
    max_run_nxt        = max_run_r;
    open_run_nxt       = open_run_r;
    open_point_nxt     = open_point_r;
    latest_point_nxt   = latest_point_r;
    latest_run_nxt     = latest_run_r;
    surface_sum_nxt    = surface_sum_r;
    ring_count_nxt     = ring_count_r;
    total_pend_nxt     = total_pend_r;
    rise_nxt           = rise_r;
    last_nxt           = last_r;
    p1_nxt             = p1_r;
    p2_nxt             = p2_r;
    out_valid_nxt      = out_valid_r && out_stall;
    out_kind_nxt       = out_kind_r;
    out_open_nxt       = out_open_r;
    out_close_nxt      = out_close_r;
    out_surface_nxt    = out_surface_r;
    out_count_nxt      = out_count_r;
    out_last_nxt       = out_last_r;

    if (cfg_valid && cfg_ready) begin
      obs_height_nxt = cfg_observer_height;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          last_nxt       = in_last;
          total_pend_nxt = in_last;
          if (in_command == vps_pkg::CMD_START) begin
            // new profile: eye at the observer, run open at the observer
            eye_distance_nxt   = in_distance;
            eye_level_nxt      = {1'b0, in_elevation} + {5'd0, obs_height_r};
            sweep_backward_nxt = in_direction;
            visible_nxt        = 1'b1;
            have_max_nxt       = 1'b0;
            max_rise_nxt       = '0;
            max_run_nxt        = '0;
            open_run_nxt       = '0;
            open_point_nxt     = idx_clamped;
            latest_point_nxt   = idx_clamped;
            latest_run_nxt     = '0;
            surface_sum_nxt    = '0;
            ring_count_nxt     = 12'd1;
            state_nxt          = in_last ? ST_SQ1 : ST_IDLE;
          end else begin
            rise_nxt         = rise_in;
            latest_run_nxt   = run_in;
            latest_point_nxt = idx_clamped;
            state_nxt        = ST_MUL1;
          end
        end
      end
      ST_MUL1: begin
        p1_nxt    = mul_p;
        state_nxt = ST_MUL2;
      end
      ST_MUL2: begin
        p2_nxt    = mul_p;
        state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (above) begin
          have_max_nxt = 1'b1;
          max_rise_nxt = rise_r;
          max_run_nxt  = latest_run_r;
          if (!visible_r) begin
            // new ring sector opens here
            open_run_nxt   = latest_run_r;
            open_point_nxt = latest_point_r;
            if (ring_count_r < vps_pkg::RING_MAX) begin
              ring_count_nxt = ring_count_r + 12'd1;
            end
          end
        end
        visible_nxt = above;
        if (close_now) begin
          state_nxt = ST_SQ1;
        end else if (last_r) begin
          state_nxt = ST_TOTAL;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SQ1: begin
        p1_nxt    = mul_p;
        state_nxt = ST_SQ2;
      end
      ST_SQ2: begin
        p2_nxt    = mul_p;
        state_nxt = ST_ACCUM;
      end
      ST_ACCUM: begin
        if (surf_sum[vps_pkg::SURF_W+1]) begin
          surface_sum_nxt = '0;
        end else if (surf_sum[vps_pkg::SURF_W]) begin
          surface_sum_nxt = vps_pkg::SURF_MAX;
        end else begin
          surface_sum_nxt = surf_sum[vps_pkg::SURF_W-1:0];
        end
        state_nxt = ST_SECT;
      end
      ST_SECT: begin
        // sector record; last of the item unless a total follows
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_kind_nxt    = vps_pkg::KIND_SECTOR;
          out_open_nxt    = open_point_r;
          out_close_nxt   = latest_point_r;
          out_surface_nxt = '0;
          out_count_nxt   = '0;
          out_last_nxt    = !total_pend_r;
          state_nxt       = total_pend_r ? ST_TOTAL : ST_IDLE;
        end
      end
      ST_TOTAL: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_kind_nxt    = vps_pkg::KIND_TOTAL;
          out_open_nxt    = '0;
          out_close_nxt   = '0;
          out_surface_nxt = surface_sum_r;
          out_count_nxt   = ring_count_r;
          out_last_nxt    = 1'b1;
          total_pend_nxt  = 1'b0;
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control and profile state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= ST_IDLE;
      obs_height_r     <= '0;
      eye_distance_r   <= '0;
      eye_level_r      <= '0;
      sweep_backward_r <= 1'b0;
      visible_r        <= 1'b1;
      have_max_r       <= 1'b0;
      max_rise_r       <= '0;
      max_run_r        <= '0;
      open_run_r       <= '0;
      open_point_r     <= '0;
      latest_point_r   <= '0;
      latest_run_r     <= '0;
      surface_sum_r    <= '0;
      ring_count_r     <= '0;
      total_pend_r     <= 1'b0;
      out_valid_r      <= 1'b0;
    end else begin
      state_r          <= state_nxt;
      obs_height_r     <= obs_height_nxt;
      eye_distance_r   <= eye_distance_nxt;
      eye_level_r      <= eye_level_nxt;
      sweep_backward_r <= sweep_backward_nxt;
      visible_r        <= visible_nxt;
      have_max_r       <= have_max_nxt;
      max_rise_r       <= max_rise_nxt;
      max_run_r        <= max_run_nxt;
      open_run_r       <= open_run_nxt;
      open_point_r     <= open_point_nxt;
      latest_point_r   <= latest_point_nxt;
      latest_run_r     <= latest_run_nxt;
      surface_sum_r    <= surface_sum_nxt;
      ring_count_r     <= ring_count_nxt;
      total_pend_r     <= total_pend_nxt;
      out_valid_r      <= out_valid_nxt;
    end
  end

  // Payload and working registers, no reset
  always_ff @(posedge clk) begin
    rise_r        <= rise_nxt;
    last_r        <= last_nxt;
    p1_r          <= p1_nxt;
    p2_r          <= p2_nxt;
    out_kind_r    <= out_kind_nxt;
    out_open_r    <= out_open_nxt;
    out_close_r   <= out_close_nxt;
    out_surface_r <= out_surface_nxt;
    out_count_r   <= out_count_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_kind_r;
  assign out_open_index   = out_open_r;
  assign out_close_index  = out_close_r;
  assign out_surface      = out_surface_r;
  assign out_sector_count = out_count_r;
  assign out_last_result  = out_last_r;

  // Checks
  a_ring_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ring_count_r <= vps_pkg::RING_MAX)
    else $error("ring count beyond sector limit");

  a_total_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r == vps_pkg::KIND_TOTAL) |-> out_last_r)
    else $error("total record not marked last");

  a_sector_no_total: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r == vps_pkg::KIND_SECTOR) |->
      (out_surface_r == '0 && out_count_r == '0))
    else $error("sector record carries total fields");

  a_point_starts_mul: assert property (@(posedge clk) disable iff (!rst_n)
    (in_take && in_command == vps_pkg::CMD_POINT) |=> (state_r == ST_MUL1))
    else $error("point item did not start slope products");

endmodule

### tb/sv/viewshed_profile_sweep_tb.sv
// Self-checking testbench for viewshed_profile_sweep: directed profiles, then random sweeps.
// Predicts sector and total records in step with the block. Uses vps_pkg and the RTL top.
`timescale 1ns / 1ps

module viewshed_profile_sweep_tb;
  import vps_pkg::*;

  // One input item, laid out as the block's input fields
  typedef struct packed {
    logic              cmd;
    logic              dir;
    logic [DIST_W-1:0] distance;
    logic [ELEV_W-1:0] elev;
    logic [IDX_W-1:0]  idx;
    logic              last;
  } point_t;

  // One result item
  typedef struct packed {
    logic              kind;
    logic [IDX_W-1:0]  open_idx;
    logic [IDX_W-1:0]  close_idx;
    logic [SURF_W-1:0] surface;
    logic [CNT_W-1:0]  count;
    logic              last_res;
  } record_t;

  // Directed row: records typed in when fixed_n is non-zero, else predicted
  typedef struct packed {
    point_t     pt;
    logic [1:0] fixed_n;
    record_t    fix0;
    record_t    fix1;
  } steer_row_t;

  localparam record_t NO_REC = '0;
  localparam int      N_ROWS = 19;
  localparam int      PHASE_ITEMS = 90;

  logic clk = 1'b0;
  logic rst_n;

  logic              cfg_valid;
  logic              cfg_ready;
  logic [OBS_W-1:0]  cfg_observer_height;

  logic              in_valid;
  logic              in_stall;
  logic              in_command;
  logic              in_direction;
  logic [DIST_W-1:0] in_distance;
  logic [ELEV_W-1:0] in_elevation;
  logic [IDX_W-1:0]  in_point_index;
  logic              in_last;

  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              out_kind;
  logic [IDX_W-1:0]  out_open_index;
  logic [IDX_W-1:0]  out_close_index;
  logic [SURF_W-1:0] out_surface;
  logic [CNT_W-1:0]  out_sector_count;
  logic              out_last_result;

  viewshed_profile_sweep uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_observer_height (cfg_observer_height),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_command          (in_command),
    .in_direction        (in_direction),
    .in_distance         (in_distance),
    .in_elevation        (in_elevation),
    .in_point_index      (in_point_index),
    .in_last             (in_last),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_kind            (out_kind),
    .out_open_index      (out_open_index),
    .out_close_index     (out_close_index),
    .out_surface         (out_surface),
    .out_sector_count    (out_sector_count),
    .out_last_result     (out_last_result)
  );

  always #5 clk = ~clk;

  // Sweep state as the block should hold it
  logic [OBS_W-1:0]          obs_height;
  logic [DIST_W-1:0]         eye_dist;
  logic [LEVEL_W-1:0]        eye_lvl;
  logic                      back_sweep;
  logic                      in_view;
  logic                      max_valid;
  logic signed [RISE_W-1:0]  max_rise;
  logic signed [RUNS_W-1:0]  max_run;
  logic signed [RUNS_W-1:0]  open_run;
  logic signed [RUNS_W-1:0]  last_run;
  logic [IDX_W-1:0]          open_pt;
  logic [IDX_W-1:0]          last_pt;
  logic [SURF_W-1:0]         surf_total;
  logic [CNT_W-1:0]          ring_cnt;

  record_t pending_records [$];
  int      fault_count = 0;
  int      burst_left = 0;
  int      rx_hold_left = 0;
  bit      rx_holding = 1'b0;

  // Directed profiles: observer-only runs, saturation both ways, backward sweep
  steer_row_t steer_rows [N_ROWS] = '{
    // point before any start, from the reset state
    '{'{CMD_POINT, 1'b0, 20'h0, 24'h0, 20'h0, 1'b1}, 2'd2,
      '{KIND_SECTOR, 20'h0, 20'h0, 40'h0, 12'h0, 1'b0},
      '{KIND_TOTAL, 20'h0, 20'h0, 40'h0, 12'h0, 1'b1}},
    // start closing at the observer
    '{'{CMD_START, 1'b0, 20'd100, 24'd200, 20'd7, 1'b1}, 2'd2,
      '{KIND_SECTOR, 20'd7, 20'd7, 40'h0, 12'h0, 1'b0},
      '{KIND_TOTAL, 20'h0, 20'h0, 40'h0, 12'd1, 1'b1}},
    '{'{CMD_START, 1'b1, 20'hFFFFF, 24'hFFFFFF, 20'hFFFFF, 1'b1}, 2'd2,
      '{KIND_SECTOR, 20'hFFFFF, 20'hFFFFF, 40'h0, 12'h0, 1'b0},
      '{KIND_TOTAL, 20'h0, 20'h0, 40'h0, 12'd1, 1'b1}},
    // surface driven past 40 bits
    '{'{CMD_START, 1'b0, 20'h0, 24'h800000, 20'd200, 1'b0}, 2'd0, NO_REC, NO_REC},
    '{'{CMD_POINT, 1'b0, 20'h10, 24'h800000, 20'd201, 1'b0}, 2'd0, NO_REC, NO_REC},
    '{'{CMD_POINT, 1'b0, 20'hFFFFF, 24'h7FFFFF, 20'd202, 1'b0}, 2'd0, NO_REC, NO_REC},
    '{'{CMD_POINT, 1'b0, 20'h20, 24'h900000, 20'd203, 1'b0}, 2'd0, NO_REC, NO_REC},
    '{'{CMD_POINT, 1'b0, 20'hFFFFF, 24'h0, 20'd204, 1'b0}, 2'd0, NO_REC, NO_REC},
    '{'{CMD_POINT, 1'b0, 20'h30, 24'hA00000, 20'd205, 1'b0}, 2'd0, NO_REC, NO_REC},
    '{'{CMD_POINT, 1'b0, 20'h0, 24'h0, 20'd206, 1'b1}, 2'd0, NO_REC, NO_REC},
    // surface driven below zero by a point behind the eye
    '{'{CMD_START, 1'b0, 20'h1000, 24'h0, 20'd300, 1'b0}, 2'd0, NO_REC, NO_REC},
    '{'{CMD_POINT, 1'b0, 20'h1001, 24'h10, 20'd301, 1'b0}, 2'd0, NO_REC, NO_REC},
    '{'{CMD_POINT, 1'b0, 20'h1002, 24'h0, 20'd302, 1'b0}, 2'd0, NO_REC, NO_REC},
    '{'{CMD_POINT, 1'b0, 20'h1100, 24'hFFFFFF, 20'd303, 1'b0}, 2'd0, NO_REC, NO_REC},
    '{'{CMD_POINT, 1'b0, 20'h0800, 24'h0, 20'd304, 1'b1}, 2'd0, NO_REC, NO_REC},
    // backward sweep, sector still open on the last point
    '{'{CMD_START, 1'b1, 20'h80000, 24'h5000, 20'd400, 1'b0}, 2'd0, NO_REC, NO_REC},
    '{'{CMD_POINT, 1'b0, 20'h90000, 24'h5000, 20'd401, 1'b0}, 2'd0, NO_REC, NO_REC},
    '{'{CMD_POINT, 1'b1, 20'h7FF00, 24'h5000, 20'd402, 1'b0}, 2'd0, NO_REC, NO_REC},
    '{'{CMD_POINT, 1'b0, 20'h0, 24'hFFFFFF, 20'd403, 1'b1}, 2'd0, NO_REC, NO_REC}
  };

  task automatic log_fault(input string what);
    fault_count++;
    if (fault_count <= 10) $display("%s", what);
  endtask

  // Close a sector at the given run: surface += run^2 - open_run^2, saturating
  function automatic void add_area(input longint run);
    longint s;
    longint o;
    o = open_run;
    s = longint'(surf_total) + run * run - o * o;
    if (s < 0) s = 0;
    if (s > longint'(SURF_MAX)) s = longint'(SURF_MAX);
    surf_total = SURF_W'(s);
  endfunction

  // Advance the sweep by one item; returns how many records it causes
  function automatic int sweep_step(input point_t it, output record_t r0, output record_t r1);
    record_t          rr [2];
    int               n;
    longint           run;
    longint           rise;
    logic             above;
    logic [IDX_W-1:0] pt;
    n = 0;
    rr[0] = NO_REC;
    rr[1] = NO_REC;
    pt = (it.idx > IDX_MAX) ? IDX_MAX : it.idx;
    if (it.cmd == CMD_START) begin
      eye_dist   = it.distance;
      eye_lvl    = LEVEL_W'(it.elev) + LEVEL_W'(obs_height);
      back_sweep = it.dir;
      in_view    = 1'b1;
      max_valid  = 1'b0;
      max_rise   = '0;
      max_run    = '0;
      open_run   = '0;
      open_pt    = pt;
      last_pt    = pt;
      last_run   = '0;
      surf_total = '0;
      ring_cnt   = CNT_W'(1);
    end else begin
      run = back_sweep ? longint'(eye_dist) - longint'(it.distance)
                       : longint'(it.distance) - longint'(eye_dist);
      rise = longint'(it.elev) - longint'(eye_lvl);
      // behind the eye counts as zero run, and zero run is never above
      if (run < 0) run = 0;
      if (run == 0) above = 1'b0;
      else if (max_valid) above = rise * max_run > max_rise * run;
      else above = rise > longint'(NOMAX_SLOPE) * run;
      if (above) begin
        max_valid = 1'b1;
        max_rise  = RISE_W'(rise);
        max_run   = RUNS_W'(run);
        if (!in_view) begin
          open_run = RUNS_W'(run);
          open_pt  = pt;
          if (ring_cnt < RING_MAX) ring_cnt++;
        end
      end else if (in_view) begin
        add_area(run);
        rr[n] = '{KIND_SECTOR, open_pt, pt, '0, '0, 1'b0};
        n++;
      end
      in_view  = above;
      last_pt  = pt;
      last_run = RUNS_W'(run);
    end
    if (it.last) begin
      if (in_view) begin
        add_area(last_run);
        rr[n] = '{KIND_SECTOR, open_pt, last_pt, '0, '0, 1'b0};
        n++;
      end
      rr[n] = '{KIND_TOTAL, '0, '0, surf_total, ring_cnt, 1'b0};
      n++;
    end
    if (n > 0) rr[n-1].last_res = 1'b1;
    r0 = rr[0];
    r1 = rr[1];
    return n;
  endfunction

  // Hand one item over, queue its records, then idle between bursts
  task automatic send_item(input point_t it, input logic [1:0] fixed_n,
                           input record_t fix0, input record_t fix1);
    record_t p0;
    record_t p1;
    int      n;
    int      gap;
    in_valid       <= 1'b1;
    in_command     <= it.cmd;
    in_direction   <= it.dir;
    in_distance    <= it.distance;
    in_elevation   <= it.elev;
    in_point_index <= it.idx;
    in_last        <= it.last;
    do @(posedge clk); while (in_stall);
    n = sweep_step(it, p0, p1);
    if (fixed_n != 2'd0) begin
      pending_records.push_back(fix0);
      if (fixed_n > 2'd1) pending_records.push_back(fix1);
    end else begin
      if (n > 0) pending_records.push_back(p0);
      if (n > 1) pending_records.push_back(p1);
    end
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      gap = ($urandom_range(0, 5) == 0) ? $urandom_range(6, 20) : $urandom_range(1, 5);
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 10);
    end
  endtask

  // Receiver: alternating stall and flow stretches, some long flow stretches
  always @(posedge clk) begin
    if (rx_hold_left == 0) begin
      rx_holding = !rx_holding;
      if (rx_holding) rx_hold_left = $urandom_range(1, 8);
      else if ($urandom_range(0, 4) == 0) rx_hold_left = $urandom_range(20, 60);
      else rx_hold_left = $urandom_range(1, 6);
    end
    rx_hold_left--;
    out_stall <= rst_n && rx_holding;
  end

  // Result checker
  always @(posedge clk) begin
    record_t got;
    record_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_kind, out_open_index, out_close_index, out_surface, out_sector_count,
              out_last_result};
      if (pending_records.size() == 0) begin
        log_fault($sformatf("unexpected record: kind %0d open %0d close %0d surf %0h cnt %0d",
                            got.kind, got.open_idx, got.close_idx, got.surface, got.count));
      end else begin
        want = pending_records.pop_front();
        if (got !== want)
          log_fault($sformatf({"record mismatch: exp kind %0d open %0d close %0d surf %0h ",
                               "cnt %0d last %0d / got kind %0d open %0d close %0d surf %0h ",
                               "cnt %0d last %0d"},
                              want.kind, want.open_idx, want.close_idx, want.surface,
                              want.count, want.last_res, got.kind, got.open_idx,
                              got.close_idx, got.surface, got.count, got.last_res));
      end
    end
  end

  // Stimulus
  initial begin
    point_t            it;
    logic [DIST_W-1:0] d;
    logic [ELEV_W-1:0] base_e;
    logic [OBS_W-1:0]  height;
    int                sent;
    int                n_pts;
    int                noise;
    int                step;
    int                tail;

    rst_n               <= 1'b0;
    cfg_valid           <= 1'b0;
    cfg_observer_height <= '0;
    in_valid            <= 1'b0;
    in_command          <= CMD_START;
    in_direction        <= 1'b0;
    in_distance         <= '0;
    in_elevation        <= '0;
    in_point_index      <= '0;
    in_last             <= 1'b0;
    obs_height = '0;
    eye_dist   = '0;
    eye_lvl    = '0;
    back_sweep = 1'b0;
    in_view    = 1'b1;
    max_valid  = 1'b0;
    max_rise   = '0;
    max_run    = '0;
    open_run   = '0;
    last_run   = '0;
    open_pt    = '0;
    last_pt    = '0;
    surf_total = '0;
    ring_cnt   = '0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part with the reset observer height
    foreach (steer_rows[i])
      send_item(steer_rows[i].pt, steer_rows[i].fixed_n, steer_rows[i].fix0, steer_rows[i].fix1);

    // Random phases, each under its own observer height
    for (int phase = 0; phase < 5; phase++) begin
      in_valid <= 1'b0;
      while (pending_records.size() != 0) @(posedge clk);
      repeat (16) @(posedge clk);
      case (phase)
        0:       height = '1;
        1:       height = '0;
        default: height = OBS_W'($urandom);
      endcase
      cfg_valid           <= 1'b1;
      cfg_observer_height <= height;
      do @(posedge clk); while (!cfg_ready);
      cfg_valid  <= 1'b0;
      obs_height = height;

      sent = 0;
      while (sent < PHASE_ITEMS) begin
        n_pts = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 8);
        // mostly well-formed profiles; some lack a start or a last, some close at once
        noise = $urandom_range(0, 9);
        it.cmd = CMD_START;
        it.dir = $urandom_range(0, 1);
        case ($urandom_range(0, 5))
          0:       it.distance = '0;
          1:       it.distance = '1;
          2:       it.distance = DIST_W'($urandom);
          default: it.distance = DIST_W'($urandom_range(262144, 786432));
        endcase
        case ($urandom_range(0, 5))
          0:       it.elev = '0;
          1:       it.elev = '1;
          default: it.elev = ELEV_W'($urandom);
        endcase
        it.idx  = IDX_W'($urandom);
        it.last = (noise == 0);
        if (noise != 1) begin
          send_item(it, 2'd0, NO_REC, NO_REC);
          sent++;
        end
        d      = it.distance;
        base_e = it.elev;
        for (int k = 0; k < n_pts; k++) begin
          case ($urandom_range(0, 15))
            0:       step = 0;
            1:       step = $urandom_range(4096, 131072);
            default: step = $urandom_range(1, 4096);
          endcase
          d = it.dir ? d - DIST_W'(step) : d + DIST_W'(step);
          it.cmd  = CMD_POINT;
          it.dir  = it.dir;
          it.distance = ($urandom_range(0, 15) == 0) ? DIST_W'($urandom) : d;
          if ($urandom_range(0, 7) == 0)
            it.elev = ELEV_W'($urandom);
          else
            it.elev = base_e + ELEV_W'($urandom_range(0, 262143)) - ELEV_W'(131072);
          it.idx  = IDX_W'($urandom);
          it.last = (k == n_pts - 1) && (noise != 2);
          // direction means nothing on a point, so toggle it freely
          send_item('{it.cmd, 1'($urandom_range(0, 1)), it.distance, it.elev, it.idx, it.last},
                    2'd0, NO_REC, NO_REC);
          sent++;
        end
      end
    end

    // Drain and finish
    in_valid <= 1'b0;
    for (tail = 0; tail < 2000 && pending_records.size() != 0; tail++) @(posedge clk);
    if (pending_records.size() != 0)
      log_fault($sformatf("%0d records never arrived", pending_records.size()));
    repeat (20) @(posedge clk);
    if (fault_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
